### src/affine_matrix_vertex_transform_top_assert.svh
// ----------------------------------------------------------------------------
// affine_matrix_vertex_transform_top_assert.svh
// Assertion macros shared by the transform block
// ----------------------------------------------------------------------------
`ifndef AFFINE_MATRIX_VERTEX_TRANSFORM_TOP_ASSERT_SVH
`define AFFINE_MATRIX_VERTEX_TRANSFORM_TOP_ASSERT_SVH

// clocked check, muted while reset is active
`define AMVT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked check that also holds through reset
`define AMVT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### src/amvt_pkg.sv
// ----------------------------------------------------------------------------
// amvt_pkg
// Types, constants and fixed-point helpers of the 4x4 transform block
// ----------------------------------------------------------------------------
package amvt_pkg;

  localparam int unsigned CoordWidth = 32;
  localparam int unsigned FracBits   = 16;
  localparam int unsigned MatDim     = 4;
  localparam int unsigned MatEntries = MatDim * MatDim;
  localparam int unsigned ProdWidth  = 2 * CoordWidth;
  // four full products summed without loss
  localparam int unsigned AccWidth   = ProdWidth + 2;

  typedef logic signed [CoordWidth-1:0] coord_t;
  typedef logic signed [ProdWidth-1:0]  prod_t;
  typedef logic signed [AccWidth-1:0]   acc_t;
  typedef logic [$clog2(MatEntries)-1:0] entry_idx_t;

  typedef enum logic [2:0] {
    OpIdentity  = 3'd0,
    OpTranslate = 3'd1,
    OpScale     = 3'd2,
    OpRotX      = 3'd3,
    OpRotY      = 3'd4,
    OpRotZ      = 3'd5,
    OpVertex    = 3'd6
  } opcode_e;

  typedef struct packed {
    opcode_e op;
    coord_t  arg_a;
    coord_t  arg_b;
    coord_t  arg_c;
    coord_t  arg_d;
  } cmd_t;

  localparam coord_t FixOne   = coord_t'(1) << FracBits;
  localparam coord_t CoordMax = {1'b0, {(CoordWidth-1){1'b1}}};
  localparam coord_t CoordMin = {1'b1, {(CoordWidth-1){1'b0}}};

  // identity matrix entry, row-major index
  function automatic coord_t ident_entry(input entry_idx_t idx);
    return (idx[3:2] == idx[1:0]) ? FixOne : '0;
  endfunction

  // arithmetic shift out the fraction, then clamp to the coordinate range
  function automatic coord_t sat_shift(input acc_t acc);
    acc_t sh;
    sh = acc >>> FracBits;
    if ((&sh[AccWidth-1:CoordWidth-1]) || !(|sh[AccWidth-1:CoordWidth-1])) begin
      return sh[CoordWidth-1:0];
    end
    return sh[AccWidth-1] ? CoordMin : CoordMax;
  endfunction

endpackage

### src/amvt_in_if.sv
// ----------------------------------------------------------------------------
// amvt_in_if
// Command channel: opcode and four Q16.16 operands
// ----------------------------------------------------------------------------
interface amvt_in_if
  import amvt_pkg::*;
();
  logic       valid;
  logic       ready;
  logic [2:0] opcode;
  coord_t     arg_a;
  coord_t     arg_b;
  coord_t     arg_c;
  coord_t     arg_d;

  modport source (output valid, opcode, arg_a, arg_b, arg_c, arg_d, input ready);
  modport sink   (input valid, opcode, arg_a, arg_b, arg_c, arg_d, output ready);
endinterface

### src/amvt_out_if.sv
// ----------------------------------------------------------------------------
// amvt_out_if
// Result channel: transformed vertex in Q16.16
// ----------------------------------------------------------------------------
interface amvt_out_if
  import amvt_pkg::*;
();
  logic   valid;
  logic   ready;
  coord_t out_x;
  coord_t out_y;
  coord_t out_z;
  coord_t out_w;

  modport source (output valid, out_x, out_y, out_z, out_w, input ready);
  modport sink   (input valid, out_x, out_y, out_z, out_w, output ready);
endinterface

### src/amvt_datapath.sv
// ----------------------------------------------------------------------------
// amvt_datapath
// One pass of matrix update or vertex transform: two multipliers per entry
// ----------------------------------------------------------------------------
module amvt_datapath
  import amvt_pkg::*;
(
  input  cmd_t   cmd_i,
  input  coord_t matrix_i [MatEntries],
  output coord_t matrix_o [MatEntries],
  output coord_t vertex_o [MatDim]
);

  prod_t prod_a [MatEntries];

  for (genvar i = 0; i < MatEntries; i++) begin : g_entry
    localparam int unsigned R = i / MatDim;
    localparam int unsigned K = i % MatDim;

    coord_t x1, y1, x2, y2;
    coord_t row_arg, vec_arg;
    logic   sub, upd;
    prod_t  prod_b;
    acc_t   sum;

    // operand of this row for translate and scale, vertex component of this column
    assign row_arg = (R == 0) ? cmd_i.arg_a : (R == 1) ? cmd_i.arg_b : cmd_i.arg_c;
    assign vec_arg = (K == 0) ? cmd_i.arg_a : (K == 1) ? cmd_i.arg_b :
                     (K == 2) ? cmd_i.arg_c : cmd_i.arg_d;

    // operand selection per opcode (s is arg_a, c is arg_b)
    always_comb begin
      x1  = '0;
      y1  = '0;
      x2  = '0;
      y2  = '0;
      sub = 1'b0;
      upd = 1'b0;
      case (cmd_i.op)
        OpTranslate: begin
          if (R < 3) begin
            x1  = matrix_i[i];
            y1  = FixOne;
            x2  = row_arg;
            y2  = matrix_i[12 + K];
            upd = 1'b1;
          end
        end
        OpScale: begin
          if (R < 3) begin
            x1  = row_arg;
            y1  = matrix_i[i];
            upd = 1'b1;
          end
        end
        OpRotX: begin
          if (R == 1) begin
            x1  = cmd_i.arg_b;
            y1  = matrix_i[4 + K];
            x2  = cmd_i.arg_a;
            y2  = matrix_i[8 + K];
            sub = 1'b1;
            upd = 1'b1;
          end else if (R == 2) begin
            x1  = cmd_i.arg_a;
            y1  = matrix_i[4 + K];
            x2  = cmd_i.arg_b;
            y2  = matrix_i[8 + K];
            upd = 1'b1;
          end
        end
        OpRotY: begin
          if (R == 0) begin
            x1  = cmd_i.arg_b;
            y1  = matrix_i[K];
            x2  = cmd_i.arg_a;
            y2  = matrix_i[8 + K];
            upd = 1'b1;
          end else if (R == 2) begin
            x1  = cmd_i.arg_b;
            y1  = matrix_i[8 + K];
            x2  = cmd_i.arg_a;
            y2  = matrix_i[K];
            sub = 1'b1;
            upd = 1'b1;
          end
        end
        OpRotZ: begin
          if (R == 0) begin
            x1  = cmd_i.arg_b;
            y1  = matrix_i[K];
            x2  = cmd_i.arg_a;
            y2  = matrix_i[4 + K];
            sub = 1'b1;
            upd = 1'b1;
          end else if (R == 1) begin
            x1  = cmd_i.arg_a;
            y1  = matrix_i[K];
            x2  = cmd_i.arg_b;
            y2  = matrix_i[4 + K];
            upd = 1'b1;
          end
        end
        OpVertex: begin
          x1 = matrix_i[i];
          y1 = vec_arg;
        end
        default: begin
          upd = 1'b0;
        end
      endcase
    end

    // products and their combination at full width
    assign prod_a[i] = prod_t'(x1) * prod_t'(y1);
    assign prod_b    = prod_t'(x2) * prod_t'(y2);
    assign sum       = sub ? (acc_t'(prod_a[i]) - acc_t'(prod_b))
                           : (acc_t'(prod_a[i]) + acc_t'(prod_b));

    // new entry: identity load, updated value, or unchanged
    always_comb begin
      if (cmd_i.op == OpIdentity) begin
        matrix_o[i] = ident_entry(entry_idx_t'(i));
      end else if (upd) begin
        matrix_o[i] = sat_shift(sum);
      end else begin
        matrix_o[i] = matrix_i[i];
      end
    end
  end

  // vertex rows: four products of a row summed, then clamped
  for (genvar r = 0; r < MatDim; r++) begin : g_row
    acc_t row_sum;
    assign row_sum = acc_t'(prod_a[r*MatDim])     + acc_t'(prod_a[r*MatDim + 1]) +
                     acc_t'(prod_a[r*MatDim + 2]) + acc_t'(prod_a[r*MatDim + 3]);
    assign vertex_o[r] = sat_shift(row_sum);
  end

endmodule

### src/affine_matrix_vertex_transform_top.sv
// ----------------------------------------------------------------------------
// affine_matrix_vertex_transform_top
// 4x4 Q16.16 homogeneous transform: matrix updates and vertex transform
// ----------------------------------------------------------------------------
//  channel   | role | payload                              | handshake
//  in_ch_i   | sink | opcode, arg_a, arg_b, arg_c, arg_d   | valid / ready
//  out_ch_o  | src  | out_x, out_y, out_z, out_w           | valid / ready
//
// One item per cycle while no vertex item stalls: an item is registered, then
// executed, and a vertex result is then held in the output register.
// The matrix update of an item is visible to the very next item.
// A vertex item waits in the input register while the output register is full
// and not taken; matrix items never wait. Reset loads the identity matrix.
// ----------------------------------------------------------------------------
module affine_matrix_vertex_transform_top
  import amvt_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  amvt_in_if.sink    in_ch_i,
  amvt_out_if.source out_ch_o
);

  logic   in_valid_q;
  cmd_t   cmd_q;
  logic   out_valid_q;
  coord_t vertex_q [MatDim];
  coord_t matrix_q [MatEntries];
  coord_t matrix_d [MatEntries];
  coord_t vertex_d [MatDim];
  logic   out_free;
  logic   exec;
  logic   vtx_fire;
  logic   in_accept;

  // handshake control
  assign out_free  = !out_valid_q || out_ch_o.ready;
  assign exec      = in_valid_q && ((cmd_q.op != OpVertex) || out_free);
  assign vtx_fire  = exec && (cmd_q.op == OpVertex);
  assign in_accept = in_ch_i.valid && in_ch_i.ready;
  assign in_ch_i.ready = !in_valid_q || exec;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (exec) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cmd_q.op    <= opcode_e'(in_ch_i.opcode);
      cmd_q.arg_a <= in_ch_i.arg_a;
      cmd_q.arg_b <= in_ch_i.arg_b;
      cmd_q.arg_c <= in_ch_i.arg_c;
      cmd_q.arg_d <= in_ch_i.arg_d;
    end
  end

  // execute stage
  amvt_datapath u_datapath (
    .cmd_i    (cmd_q),
    .matrix_i (matrix_q),
    .matrix_o (matrix_d),
    .vertex_o (vertex_d)
  );

  // matrix state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MatEntries; i++) begin
        matrix_q[i] <= ident_entry(entry_idx_t'(i));
      end
    end else if (exec) begin
      matrix_q <= matrix_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (vtx_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ch_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vtx_fire) begin
      vertex_q <= vertex_d;
    end
  end

  assign out_ch_o.valid = out_valid_q;
  assign out_ch_o.out_x = vertex_q[0];
  assign out_ch_o.out_y = vertex_q[1];
  assign out_ch_o.out_z = vertex_q[2];
  assign out_ch_o.out_w = vertex_q[3];

  // checks
  `include "affine_matrix_vertex_transform_top_assert.svh"

  `AMVT_ASSERT(a_vtx_needs_slot, vtx_fire |-> out_free, "vertex executed into a full output")
  `AMVT_ASSERT(a_out_from_vertex, $rose(out_valid_q) |-> $past(vtx_fire), "result without vertex")
  `AMVT_ASSERT(a_stall_keeps_item, (in_valid_q && !exec) |=> in_valid_q, "stalled item dropped")
  `AMVT_ASSERT_ALWAYS(a_reset_idle, (!rst_ni && $past(!rst_ni)) |-> (!in_valid_q && !out_valid_q), "busy in reset")

endmodule

### tb/affine_matrix_vertex_transform_top_tb.sv
// ----------------------------------------------------------------------------
// affine_matrix_vertex_transform_top_tb
// Self-checking bench for the 4x4 Q16.16 transform block: a queue-fed driver
// offers opcode items, a scoreboard keeps its own copy of the matrix and
// predicts every transformed vertex, and a monitor checks each result item
// field by field under random idling on both channels.
// ----------------------------------------------------------------------------
module affine_matrix_vertex_transform_top_tb;
  import amvt_pkg::*;

  localparam int          RandItems     = 1950;
  localparam int          IdleLimit     = 2000;
  localparam int          HoldCycles    = 400;
  localparam int          CalmItems     = 200;
  localparam int          MaxPrinted    = 40;
  localparam logic [2:0]  OpUnused      = 3'd7;
  localparam int unsigned SpanTranslate = 8 * 65536;
  localparam int unsigned SpanScale     = 2 * 65536;
  localparam int unsigned SpanVertex    = 16 * 65536;

  typedef logic signed [95:0] wide_t;

  typedef struct {
    logic [2:0] opcode;
    coord_t     a;
    coord_t     b;
    coord_t     c;
    coord_t     d;
  } xform_cmd_t;

  typedef struct {
    coord_t x;
    coord_t y;
    coord_t z;
    coord_t w;
  } vertex_t;

  logic clk_i;
  logic rst_ni;

  amvt_in_if  in_ch ();
  amvt_out_if out_ch ();

  affine_matrix_vertex_transform_top uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_ch_i  (in_ch),
    .out_ch_o (out_ch)
  );

  xform_cmd_t cmd_q[$];
  vertex_t    expected_vertices[$];
  coord_t     cur_matrix [MatEntries];

  int   mismatches;
  int   taken_cnt;
  int   in_gap;
  int   out_gap;
  logic in_fire;
  logic calm;
  logic hold_off;

  // clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // scoreboard arithmetic
  // ---------------------------------------------------------------------------

  function automatic wide_t mul(input coord_t x, input coord_t y);
    return wide_t'(x) * wide_t'(y);
  endfunction

  // drop the fraction (floor), then clamp to the coordinate range
  function automatic coord_t clamp_q(input wide_t acc);
    wide_t sh;
    sh = acc >>> FracBits;
    if (sh > wide_t'(CoordMax)) return CoordMax;
    if (sh < wide_t'(CoordMin)) return CoordMin;
    return sh[CoordWidth-1:0];
  endfunction

  function automatic coord_t identity_entry(input int idx);
    return (idx % 5 == 0) ? FixOne : '0;
  endfunction

  // update the matrix copy, or queue the expected vertex
  task automatic apply_command(input xform_cmd_t cmd);
    coord_t  src [MatEntries];
    coord_t  arg [3];
    coord_t  row_sum [4];
    vertex_t v;
    src    = cur_matrix;
    arg[0] = cmd.a;
    arg[1] = cmd.b;
    arg[2] = cmd.c;
    case (cmd.opcode)
      OpIdentity: begin
        for (int i = 0; i < MatEntries; i++) cur_matrix[i] = identity_entry(i);
      end
      OpTranslate: begin
        for (int r = 0; r < 3; r++)
          for (int k = 0; k < 4; k++)
            cur_matrix[r*4+k] = clamp_q(mul(src[r*4+k], FixOne) + mul(arg[r], src[12+k]));
      end
      OpScale: begin
        for (int r = 0; r < 3; r++)
          for (int k = 0; k < 4; k++)
            cur_matrix[r*4+k] = clamp_q(mul(arg[r], src[r*4+k]));
      end
      OpRotX: begin
        for (int k = 0; k < 4; k++) begin
          cur_matrix[4+k] = clamp_q(mul(cmd.b, src[4+k]) - mul(cmd.a, src[8+k]));
          cur_matrix[8+k] = clamp_q(mul(cmd.a, src[4+k]) + mul(cmd.b, src[8+k]));
        end
      end
      OpRotY: begin
        for (int k = 0; k < 4; k++) begin
          cur_matrix[k]   = clamp_q(mul(cmd.b, src[k]) + mul(cmd.a, src[8+k]));
          cur_matrix[8+k] = clamp_q(mul(cmd.b, src[8+k]) - mul(cmd.a, src[k]));
        end
      end
      OpRotZ: begin
        for (int k = 0; k < 4; k++) begin
          cur_matrix[k]   = clamp_q(mul(cmd.b, src[k]) - mul(cmd.a, src[4+k]));
          cur_matrix[4+k] = clamp_q(mul(cmd.a, src[k]) + mul(cmd.b, src[4+k]));
        end
      end
      OpVertex: begin
        for (int r = 0; r < 4; r++)
          row_sum[r] = clamp_q(mul(src[r*4+0], cmd.a) + mul(src[r*4+1], cmd.b) +
                               mul(src[r*4+2], cmd.c) + mul(src[r*4+3], cmd.d));
        v.x = row_sum[0];
        v.y = row_sum[1];
        v.z = row_sum[2];
        v.w = row_sum[3];
        expected_vertices.push_back(v);
      end
      default: ;  // unused opcode leaves everything as is
    endcase
  endtask

  task automatic report_mismatch(input string field, input coord_t got, input coord_t want);
    if (mismatches < MaxPrinted)
      $display("[%0t] %s: got %0d (0x%08h), want %0d (0x%08h)",
               $realtime, field, got, got, want, want);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic push_cmd(input logic [2:0] op, input coord_t a, input coord_t b,
                          input coord_t c, input coord_t d);
    xform_cmd_t cmd;
    cmd.opcode = op;
    cmd.a      = a;
    cmd.b      = b;
    cmd.c      = c;
    cmd.d      = d;
    cmd_q.push_back(cmd);
  endtask

  // uniform value in [-span, span] raw units
  function automatic coord_t near_fix(input int unsigned span);
    return coord_t'(int'($urandom_range(0, 2 * span)) - int'(span));
  endfunction

  // range limits or any bit pattern
  function automatic coord_t wild_fix();
    case ($urandom_range(0, 3))
      0:       return CoordMax;
      1:       return CoordMin;
      default: return coord_t'($urandom);
    endcase
  endfunction

  // one matrix update with sensible operands, now and then extreme ones
  task automatic push_matrix_op();
    logic [2:0] op;
    real        ang;
    coord_t     s;
    coord_t     c;
    op = 3'($urandom_range(OpTranslate, OpRotZ));
    if ($urandom_range(0, 15) == 0) begin
      push_cmd(op, wild_fix(), wild_fix(), wild_fix(), coord_t'($urandom));
    end else if (op == OpTranslate) begin
      push_cmd(op, near_fix(SpanTranslate), near_fix(SpanTranslate),
               near_fix(SpanTranslate), coord_t'($urandom));
    end else if (op == OpScale) begin
      push_cmd(op, near_fix(SpanScale), near_fix(SpanScale), near_fix(SpanScale),
               coord_t'($urandom));
    end else begin
      ang = $urandom_range(0, 62831) / 10000.0;
      s   = coord_t'($rtoi($sin(ang) * 65536.0));
      c   = coord_t'($rtoi($cos(ang) * 65536.0));
      push_cmd(op, s, c, coord_t'($urandom), coord_t'($urandom));
    end
  endtask

  task automatic push_vertex();
    if ($urandom_range(0, 9) == 0)
      push_cmd(OpVertex, wild_fix(), wild_fix(), wild_fix(), wild_fix());
    else
      push_cmd(OpVertex, near_fix(SpanVertex), near_fix(SpanVertex), near_fix(SpanVertex),
               ($urandom_range(0, 3) == 0) ? near_fix(SpanScale) : FixOne);
  endtask

  // ---------------------------------------------------------------------------
  // input driver: next item or a random idle gap at the falling edge after the last one was taken
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni && (in_fire || !in_ch.valid)) begin
      if (in_gap > 0) begin
        in_ch.valid <= 1'b0;
        in_gap      <= in_gap - 1;
      end else if (cmd_q.size() > 0) begin
        in_ch.valid  <= 1'b1;
        in_ch.opcode <= cmd_q[0].opcode;
        in_ch.arg_a  <= cmd_q[0].a;
        in_ch.arg_b  <= cmd_q[0].b;
        in_ch.arg_c  <= cmd_q[0].c;
        in_ch.arg_d  <= cmd_q[0].d;
        void'(cmd_q.pop_front());
        if (!calm && $urandom_range(0, 7) == 0) in_gap <= $urandom_range(1, 9);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result ready: random stalls, plus the long hold-off
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_off) begin
        out_ch.ready <= 1'b0;
      end else if (out_gap > 0) begin
        out_ch.ready <= 1'b0;
        out_gap      <= out_gap - 1;
      end else begin
        out_ch.ready <= 1'b1;
        if (!calm && $urandom_range(0, 7) == 0) out_gap <= $urandom_range(1, 9);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: check results, feed accepted items to the scoreboard
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    xform_cmd_t cmd;
    vertex_t    want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_vertices.size() == 0) begin
        report_mismatch("unexpected result, out_x", out_ch.out_x, '0);
      end else begin
        want = expected_vertices.pop_front();
        if (out_ch.out_x !== want.x) report_mismatch("out_x", out_ch.out_x, want.x);
        if (out_ch.out_y !== want.y) report_mismatch("out_y", out_ch.out_y, want.y);
        if (out_ch.out_z !== want.z) report_mismatch("out_z", out_ch.out_z, want.z);
        if (out_ch.out_w !== want.w) report_mismatch("out_w", out_ch.out_w, want.w);
      end
    end
    if (rst_ni && in_ch.valid && in_ch.ready) begin
      cmd.opcode = in_ch.opcode;
      cmd.a      = in_ch.arg_a;
      cmd.b      = in_ch.arg_b;
      cmd.c      = in_ch.arg_c;
      cmd.d      = in_ch.arg_d;
      apply_command(cmd);
      taken_cnt <= taken_cnt + 1;
    end
    in_fire <= rst_ni && in_ch.valid && in_ch.ready;
    calm    <= cmd_q.size() < CalmItems;
  end

  // long receiver hold-off while items keep coming
  initial begin
    hold_off = 1'b0;
    wait (taken_cnt >= 700);
    @(posedge clk_i);
    hold_off = 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_off = 1'b0;
  end

  // watchdog: too long without any item moving
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IdleLimit) begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("affine_matrix_vertex_transform_top: mismatch");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int target;
    rst_ni       = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.opcode = OpIdentity;
    in_ch.arg_a  = '0;
    in_ch.arg_b  = '0;
    in_ch.arg_c  = '0;
    in_ch.arg_d  = '0;
    out_ch.ready = 1'b0;
    in_fire      = 1'b0;
    calm         = 1'b0;
    in_gap       = 0;
    out_gap      = 0;
    mismatches   = 0;
    taken_cnt    = 0;
    for (int i = 0; i < MatEntries; i++) cur_matrix[i] = identity_entry(i);

    // directed: identity after reset, operand extremes, every opcode
    push_cmd(OpVertex, 32'sd65536, 32'sd131072, -32'sd196608, FixOne);
    push_cmd(OpVertex, CoordMax, CoordMin, '0, -FixOne);
    // unused opcode must be ignored
    push_cmd(OpUnused, CoordMax, CoordMin, coord_t'($urandom), coord_t'($urandom));
    push_cmd(OpVertex, FixOne, FixOne, FixOne, FixOne);
    // translate, one offset saturating an entry
    push_cmd(OpTranslate, 32'sd196608, -FixOne, CoordMax, coord_t'($urandom));
    push_cmd(OpVertex, FixOne, -FixOne, 32'sd32768, FixOne);
    // scale driving entries to both limits, with overflow at the upper one
    push_cmd(OpScale, CoordMax, CoordMin, 32'sd32768, coord_t'($urandom));
    push_cmd(OpVertex, CoordMax, CoordMax, CoordMin, CoordMax);
    // identity with nonzero operands, which are ignored
    push_cmd(OpIdentity, CoordMax, CoordMin, CoordMax, CoordMin);
    push_cmd(OpVertex, 32'sd100000, -32'sd7, 32'sd1, -32'sd65535);
    // rotations with unit sine and cosine pairs (magnitudes 0.6 and 0.8)
    push_cmd(OpRotX, 32'sd39322, 32'sd52429, CoordMax, CoordMin);
    push_cmd(OpVertex, FixOne, 32'sd131072, 32'sd196608, FixOne);
    push_cmd(OpRotY, -32'sd39322, 32'sd52429, CoordMin, CoordMax);
    push_cmd(OpVertex, FixOne, 32'sd131072, 32'sd196608, FixOne);
    push_cmd(OpRotZ, 32'sd52429, -32'sd39322, '0, '0);
    push_cmd(OpVertex, FixOne, 32'sd131072, 32'sd196608, FixOne);
    // non-unit sine and cosine, driving the rows into saturation
    push_cmd(OpRotY, CoordMax, CoordMax, '0, '0);
    push_cmd(OpRotX, CoordMin, CoordMax, '0, '0);
    push_cmd(OpRotZ, CoordMin, CoordMin, '0, '0);
    push_cmd(OpVertex, CoordMin, CoordMax, CoordMin, CoordMax);
    push_cmd(OpIdentity, '0, '0, '0, '0);
    push_cmd(OpVertex, CoordMin, CoordMin, CoordMin, CoordMin);
    push_cmd(OpVertex, '0, '0, '0, '0);

    // random: groups of an optional identity, one to four updates and one to six vertices; some noise
    target = cmd_q.size() + RandItems;
    while (cmd_q.size() < target) begin
      if ($urandom_range(0, 4) != 0) begin
        if ($urandom_range(0, 1) == 0) push_cmd(OpIdentity, coord_t'($urandom),
                                                coord_t'($urandom), coord_t'($urandom),
                                                coord_t'($urandom));
        repeat ($urandom_range(1, 4)) push_matrix_op();
        repeat ($urandom_range(1, 6)) push_vertex();
      end else begin
        repeat ($urandom_range(1, 4))
          push_cmd(3'($urandom_range(0, 7)), coord_t'($urandom), coord_t'($urandom),
                   coord_t'($urandom), coord_t'($urandom));
      end
    end

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    wait (cmd_q.size() == 0);
    while (in_ch.valid) @(posedge clk_i);
    while (expected_vertices.size() > 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("affine_matrix_vertex_transform_top: match");
    end else begin
      $display("affine_matrix_vertex_transform_top: mismatch");
    end
    $finish;
  end

endmodule

### files.f
+incdir+src
src/amvt_pkg.sv
src/amvt_in_if.sv
src/amvt_out_if.sv
src/amvt_datapath.sv
src/affine_matrix_vertex_transform_top.sv
tb/affine_matrix_vertex_transform_top_tb.sv
